// ===== hdl/sha256_byte_stream_hasher_assert.svh =====
// ---------------------------------------------------------------------------
// sha256_byte_stream_hasher_assert
// Assertion macros for the SHA-256 byte stream hasher.
// ---------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// Check that a condition implies another on the same edge.
`define SHA_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies another on the next edge.
`define SHA_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/sha256_pkg.sv =====
// ---------------------------------------------------------------------------
// sha256_pkg
// Types, constants and round functions shared by the SHA-256 hasher.
// ---------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned BlkBytes = 64;
    localparam int unsigned LenPos   = 56;
    localparam int unsigned Rounds   = 64;
    localparam int unsigned CntWidth = 61;
    localparam logic [7:0]  PadMark  = 8'h80;

    localparam logic OpAbsorb = 1'b0;
    localparam logic OpFinish = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    // datapath commands from controller
    typedef struct packed {
        logic       wr_byte;    // write byte into buffer at pad pointer
        logic [7:0] wr_data;
        logic       ptr_clr;
        logic       ld_block;   // load working vars from hash, reset round
        logic       do_round;
        logic       upd_hash;
        logic       init_hash;
        logic       len_sel;    // write length byte instead of wr_data
        logic       cnt_inc;
        logic       emit_shift; // rotate hash words toward output
    } t_cmd;

    typedef struct packed {
        logic [5:0] ptr;
        logic       last_round;
    } t_sts;

    localparam logic [255:0] Iv = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ===== hdl/sha256_ctrl.sv =====
// ---------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: absorb, padding, compression and digest readout.
// ---------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sha256_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_word_index,
    output sha256_pkg::t_cmd      o_cmd,
    input  sha256_pkg::t_sts      i_sts
);

    sha256_pkg::t_state r_state, n_state;
    logic       r_finish, n_finish;   // compressing as part of a finish
    logic       r_pass2, n_pass2;     // second padded block still due
    logic [2:0] r_widx, n_widx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha256_pkg::ST_IDLE;
            r_finish <= 1'b0;
            r_pass2  <= 1'b0;
            r_widx   <= '0;
        end else begin
            r_state  <= n_state;
            r_finish <= n_finish;
            r_pass2  <= n_pass2;
            r_widx   <= n_widx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_finish = r_finish;
        n_pass2  = r_pass2;
        n_widx   = r_widx;
        o_cmd    = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            sha256_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.wr_byte = 1'b1;
                    if (i_in_data.op == sha256_pkg::OpAbsorb) begin
                        o_cmd.wr_data = i_in_data.data_byte;
                        o_cmd.cnt_inc = 1'b1;
                        if (i_sts.ptr == 6'd63) begin
                            n_finish = 1'b0;
                            n_state  = sha256_pkg::ST_LOAD;
                        end
                    end else begin
                        o_cmd.wr_data = sha256_pkg::PadMark;
                        n_finish = 1'b1;
                        n_pass2  = (i_sts.ptr > 6'd55);
                        n_state  = (i_sts.ptr == 6'd63) ? sha256_pkg::ST_LOAD
                                                        : sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                // zero fill, then length bytes at 56-63 unless r_pass2
                o_cmd.wr_byte = 1'b1;
                if (!r_pass2 && i_sts.ptr >= 6'd56)
                    o_cmd.len_sel = 1'b1;
                if (i_sts.ptr == 6'd63)
                    n_state = sha256_pkg::ST_LOAD;
            end
            sha256_pkg::ST_LOAD: begin
                o_cmd.ld_block = 1'b1;
                n_state = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_ROUND: begin
                o_cmd.do_round = 1'b1;
                if (i_sts.last_round)
                    n_state = sha256_pkg::ST_UPDATE;
            end
            sha256_pkg::ST_UPDATE: begin
                o_cmd.upd_hash = 1'b1;
                if (!r_finish) begin
                    n_state = sha256_pkg::ST_IDLE;
                end else if (r_pass2) begin
                    n_pass2 = 1'b0;
                    n_state = sha256_pkg::ST_PAD;
                end else begin
                    n_widx  = '0;
                    n_state = sha256_pkg::ST_EMIT;
                end
            end
            sha256_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_shift = 1'b1;
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        o_cmd.init_hash = 1'b1;
                        o_cmd.ptr_clr   = 1'b1;
                        n_finish = 1'b0;
                        n_state  = sha256_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    assign o_word_index = r_widx;

endmodule

// ===== hdl/sha256_dp.sv =====
// ---------------------------------------------------------------------------
// sha256_dp
// Message schedule window (filled byte by byte as the block buffer),
// round unit and hash words.
// ---------------------------------------------------------------------------
module sha256_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha256_pkg::t_cmd i_cmd,
    output sha256_pkg::t_sts o_sts,
    output logic [31:0]      o_digest_word
);

    logic [5:0]   r_ptr;
    logic [sha256_pkg::CntWidth-1:0] r_cnt;
    logic [255:0] r_hash;
    logic [31:0]  r_v [8];
    logic [31:0]  r_w [16];
    logic [5:0]   r_rnd;
    logic [7:0]   n_byte;
    logic [63:0]  n_bits;
    logic [31:0]  n_w, n_t1, n_t2, n_s0, n_s1;

    assign n_bits = {r_cnt, 3'b000};

    always_comb begin
        n_byte = i_cmd.wr_data;
        if (i_cmd.len_sel)
            n_byte = n_bits[8 * (7 - r_ptr[2:0]) +: 8];
    end

    // next schedule word from the 16-word window
    assign n_s0 = sha256_pkg::ror(r_w[1], 7) ^ sha256_pkg::ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign n_s1 = sha256_pkg::ror(r_w[14], 17) ^ sha256_pkg::ror(r_w[14], 19)
                ^ (r_w[14] >> 10);
    assign n_w  = r_w[0] + n_s0 + r_w[9] + n_s1;

    assign n_t1 = r_v[7]
                + (sha256_pkg::ror(r_v[4], 6) ^ sha256_pkg::ror(r_v[4], 11)
                   ^ sha256_pkg::ror(r_v[4], 25))
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + sha256_pkg::round_k(r_rnd) + r_w[0];
    assign n_t2 = (sha256_pkg::ror(r_v[0], 2) ^ sha256_pkg::ror(r_v[0], 13)
                   ^ sha256_pkg::ror(r_v[0], 22))
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_cnt  <= '0;
            r_hash <= sha256_pkg::Iv;
            r_rnd  <= '0;
        end else begin
            if (i_cmd.ptr_clr)
                r_ptr <= '0;
            else if (i_cmd.wr_byte)
                r_ptr <= r_ptr + 6'd1;
            if (i_cmd.ptr_clr)
                r_cnt <= '0;
            else if (i_cmd.cnt_inc)
                r_cnt <= r_cnt + 1'b1;
            if (i_cmd.ld_block)
                r_rnd <= '0;
            else if (i_cmd.do_round)
                r_rnd <= r_rnd + 6'd1;
            if (i_cmd.init_hash)
                r_hash <= sha256_pkg::Iv;
            else if (i_cmd.upd_hash) begin
                for (int i = 0; i < 8; i++)
                    r_hash[32 * (7 - i) +: 32] <= r_hash[32 * (7 - i) +: 32] + r_v[i];
            end else if (i_cmd.emit_shift)
                r_hash <= {r_hash[223:0], r_hash[255:224]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_block) begin
            for (int i = 0; i < 8; i++)
                r_v[i] <= r_hash[32 * (7 - i) +: 32];
        end else if (i_cmd.do_round) begin
            r_v[0] <= n_t1 + n_t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + n_t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
        // land bytes straight in the window, first byte in the top lane
        if (i_cmd.wr_byte) begin
            r_w[r_ptr[5:2]][8 * (3 - r_ptr[1:0]) +: 8] <= n_byte;
        end else if (i_cmd.do_round) begin
            for (int i = 0; i < 15; i++)
                r_w[i] <= r_w[i + 1];
            r_w[15] <= n_w;
        end
    end

    assign o_sts.ptr        = r_ptr;
    assign o_sts.last_round = (r_rnd == 6'd63);
    assign o_digest_word    = r_hash[255:224];

endmodule

// ===== hdl/sha256_byte_stream_hasher.sv =====
// ---------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream; finish pads and reads out eight digest words.
// ---------------------------------------------------------------------------
//  channel | direction | payload    | handshake
//  in      | input     | t_in_item  | i_in_valid / o_in_ready
//  out     | output    | t_out_item | o_out_valid / i_out_ready
//
// Each absorbed byte is written into the block; every 64th byte starts the
// round unit (a load, one round a cycle, then the hash update).
// Finish: pad mark, zero fill and length bytes (spilling into a second
// block when needed), one or two compressions, then eight beats.
// Input is held off during padding, compression and readout; out stalls hold state.
// Synchronous active-low reset loads the initial hash values.
module sha256_byte_stream_hasher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sha256_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sha256_pkg::t_out_item o_out_data
);

    sha256_pkg::t_cmd w_cmd;
    sha256_pkg::t_sts w_sts;
    logic [2:0]       w_widx;
    logic [31:0]      w_word;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_word_index(w_widx),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    sha256_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_digest_word(w_word)
    );

    assign o_out_data.digest_word = w_word;
    assign o_out_data.word_index  = w_widx;
    assign o_out_data.last_word   = (w_widx == 3'd7);

`include "sha256_byte_stream_hasher_assert.svh"

    `SHA_ASSERT_IMP(a_no_in_during_out, i_clk, i_rst_n, o_out_valid, !o_in_ready, "in ready during readout")
    `SHA_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, o_out_valid && i_out_ready && o_out_data.last_word, !o_out_valid, "readout ran past last word")
    `SHA_ASSERT_IMP(a_cmd_excl, i_clk, i_rst_n, w_cmd.do_round, !w_cmd.wr_byte && !w_cmd.upd_hash, "round overlaps buffer write")

endmodule
